// File: sv/mlfq_pkg.sv
`timescale 1ns / 1ps

package mlfq_pkg;

   // Defaults for the top-level parameters.
   localparam int NUM_TASKS_DEF  = 16;
   localparam int NUM_LEVELS_DEF = 4;

   // The base slice register.
   localparam int                BASE_W     = 4;
   localparam logic [BASE_W-1:0] BASE_RESET = 4'd2;

   // Operation codes carried by a request.
   typedef enum logic [1:0] {
      MODE_ENQ  = 2'd0,
      MODE_DEQ  = 2'd1,
      MODE_PICK = 2'd2,
      MODE_TICK = 2'd3
   } mode_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_INFO,
      S_ESCAN_A,
      S_ESCAN_B,
      S_ESCAN_C,
      S_ISHIFT_A,
      S_ISHIFT_B,
      S_DSCAN_A,
      S_DSCAN_B,
      S_DSHIFT_A,
      S_DSHIFT_B,
      S_HEAD,
      S_DONE
   } state_type;

endpackage

// File: sv/mlfq_ready_queue_scheduler.sv
`timescale 1ns / 1ps

// Ready queue for NUM_TASKS tasks over NUM_LEVELS priority levels, kept as one
// list ordered by level as tasks are enqueued and FIFO within a level; a tick
// does not reorder it. A request on the req_ channel carries an operation
// (enqueue, dequeue, pick, tick), a task id and a fresh flag. Every request
// gives exactly one response on the rsp_ channel, which reports the head of
// the list, the queue length, the addressed task's level, and the reschedule
// and error flags. The base slice is to be written through csr_we and csr_wdata
// only while the block is idle; the block itself does not enforce this.
// A request is first read from the task table and then works through the order
// memory one entry at a time, with one read port. An enqueue in front of place
// k of a list of n reads k+1 entries and moves the n-k entries behind it; an
// append reads all n entries, and a dequeue scans to the task and moves the
// entries behind it. The longest request is an enqueue one place before the
// tail of a list of 15.
// req_ready is high only while the sequencer is idle.
// The response sits in an output register; while the receiver stalls, the next
// request is still taken and worked on, and waits at its end for that register.
// Reset empties the list, puts every task at level 0 with an empty slice, sets
// the base slice to 2 and drops rsp_valid. No clearing pass is needed.
module mlfq_ready_queue_scheduler #(
   parameter int NUM_TASKS  = mlfq_pkg::NUM_TASKS_DEF,
   parameter int NUM_LEVELS = mlfq_pkg::NUM_LEVELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [mlfq_pkg::BASE_W-1:0] csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_mode,
   input  logic [3:0]                 req_task_id,
   input  logic                       req_fresh,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_pick_valid,
   output logic [3:0]                 rsp_picked_task,
   output logic                       rsp_resched,
   output logic                       rsp_error,
   output logic [4:0]                 rsp_queued_count,
   output logic [1:0]                 rsp_task_level
);

   import mlfq_pkg::*;

   localparam int IW = $clog2(NUM_TASKS);
   localparam int CW = $clog2(NUM_TASKS + 1);
   localparam int LW = $clog2(NUM_LEVELS);
   localparam int SW = BASE_W + NUM_LEVELS - 1;
   localparam int TW = LW + SW;

   // Memories: the ordered list and the per-task level and slice.
   logic [IW-1:0] order_mem [NUM_TASKS];
   logic [TW-1:0] info_mem  [NUM_TASKS];

   // Configuration and queue state.
   logic [BASE_W-1:0]    base_ff;
   logic [CW-1:0]        len_ff, len_in;
   logic [NUM_TASKS-1:0] queued_ff, queued_in;
   logic [NUM_TASKS-1:0] info_vld_ff, info_vld_in;

   // Sequencer.
   state_type     state_ff, state_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] pos_ff, pos_in;

   // Latched request and working results.
   mode_type      mode_ff;
   logic [3:0]    tid_ff;
   logic          fresh_ff;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic          resched_ff, resched_in;
   logic          err_ff, err_in;

   // Memory ports.
   logic [IW-1:0] order_raddr, order_waddr, order_wdata;
   logic          order_we;
   logic [IW-1:0] order_rd_ff;
   logic [IW-1:0] info_raddr, info_waddr;
   logic [TW-1:0] info_wdata;
   logic          info_we;
   logic [TW-1:0] info_rd_ff;
   logic          info_vld_rd_ff;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_pick_valid_ff;
   logic [3:0]    rsp_picked_task_ff;
   logic          rsp_resched_ff;
   logic          rsp_error_ff;
   logic [4:0]    rsp_queued_count_ff;
   logic [1:0]    rsp_task_level_ff;
   logic          rsp_load;

   // Helpers decoded from the latched request and the table read.
   logic [IW-1:0] tid_idx;
   logic          in_range;
   logic          req_xfer;
   logic [LW-1:0] cur_lvl;
   logic [SW-1:0] cur_slc;
   logic [LW-1:0] enq_lvl, tick_lvl;
   logic [SW-1:0] enq_slc, tick_slc, tick_dec;

   assign req_xfer = req_valid && req_ready;
   assign tid_idx  = IW'(tid_ff);
   assign in_range = 32'(tid_ff) < NUM_TASKS;

   // An entry never written reads as level 0 with an empty slice.
   assign cur_lvl = info_vld_rd_ff ? info_rd_ff[TW-1:SW] : '0;
   assign cur_slc = info_vld_rd_ff ? info_rd_ff[SW-1:0]  : '0;

   // Enqueue: a fresh task restarts at level 0, an empty slice is reloaded.
   always_comb begin
      enq_lvl = fresh_ff ? '0 : cur_lvl;
      enq_slc = fresh_ff ? '0 : cur_slc;
      if (enq_slc == '0) begin
         enq_slc = SW'(base_ff) << enq_lvl;
      end
   end

   // Tick: count the slice down; an exhausted slice demotes and reloads.
   assign tick_dec = (cur_slc != '0) ? cur_slc - SW'(1) : '0;

   always_comb begin
      tick_lvl = cur_lvl;
      tick_slc = tick_dec;
      if (tick_dec == '0) begin
         if (cur_lvl < LW'(NUM_LEVELS - 1)) begin
            tick_lvl = cur_lvl + LW'(1);
         end
         tick_slc = SW'(base_ff) << tick_lvl;
      end
   end

   // Sequencer next state and memory controls.
   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      queued_in   = queued_ff;
      info_vld_in = info_vld_ff;
      lvl_in      = lvl_ff;
      resched_in  = resched_ff;
      err_in      = err_ff;
      order_raddr = '0;
      order_we    = 1'b0;
      order_waddr = '0;
      order_wdata = '0;
      info_raddr  = tid_idx;
      info_we     = 1'b0;
      info_waddr  = tid_idx;
      info_wdata  = '0;
      rsp_load    = 1'b0;
      req_ready   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            info_raddr = IW'(req_task_id);
            if (req_valid) begin
               resched_in = 1'b0;
               err_in     = 1'b0;
               lvl_in     = '0;
               i_in       = '0;
               state_in   = S_INFO;
            end
         end

         S_INFO: begin
            state_in = S_HEAD;
            unique case (mode_ff)
               MODE_ENQ: begin
                  if (!in_range) begin
                     err_in = 1'b1;
                  end else if (queued_ff[tid_idx] || len_ff >= CW'(NUM_TASKS)) begin
                     err_in = 1'b1;
                     lvl_in = cur_lvl;
                  end else begin
                     info_we              = 1'b1;
                     info_wdata           = {enq_lvl, enq_slc};
                     info_vld_in[tid_idx] = 1'b1;
                     lvl_in               = enq_lvl;
                     state_in             = S_ESCAN_A;
                  end
               end
               MODE_DEQ: begin
                  if (!in_range) begin
                     err_in = 1'b1;
                  end else begin
                     lvl_in = cur_lvl;
                     if (!queued_ff[tid_idx]) begin
                        err_in = 1'b1;
                     end else begin
                        state_in = S_DSCAN_A;
                     end
                  end
               end
               MODE_PICK: begin
                  lvl_in = '0;
               end
               MODE_TICK: begin
                  if (in_range) begin
                     info_we              = 1'b1;
                     info_wdata           = {tick_lvl, tick_slc};
                     info_vld_in[tid_idx] = 1'b1;
                     lvl_in               = tick_lvl;
                     resched_in           = (tick_dec == '0);
                  end
               end
            endcase
         end

         // Find the first queued task whose level number is greater than the new one's.
         S_ESCAN_A: begin
            order_raddr = i_ff[IW-1:0];
            if (i_ff == len_ff) begin
               pos_in   = i_ff;
               state_in = S_ISHIFT_A;
            end else begin
               state_in = S_ESCAN_B;
            end
         end

         S_ESCAN_B: begin
            info_raddr = order_rd_ff;
            state_in   = S_ESCAN_C;
         end

         S_ESCAN_C: begin
            if (cur_lvl > lvl_ff) begin
               pos_in   = i_ff;
               i_in     = len_ff;
               state_in = S_ISHIFT_A;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_ESCAN_A;
            end
         end

         // Move the tail back one place, then write the new task.
         S_ISHIFT_A: begin
            order_raddr = IW'(i_ff - CW'(1));
            if (i_ff == pos_ff) begin
               order_we           = 1'b1;
               order_waddr        = pos_ff[IW-1:0];
               order_wdata        = tid_idx;
               len_in             = len_ff + CW'(1);
               queued_in[tid_idx] = 1'b1;
               state_in           = S_HEAD;
            end else begin
               state_in = S_ISHIFT_B;
            end
         end

         S_ISHIFT_B: begin
            order_we    = 1'b1;
            order_waddr = i_ff[IW-1:0];
            order_wdata = order_rd_ff;
            i_in        = i_ff - CW'(1);
            state_in    = S_ISHIFT_A;
         end

         // Find the task to remove.
         S_DSCAN_A: begin
            order_raddr = i_ff[IW-1:0];
            if (i_ff == len_ff) begin
               queued_in[tid_idx] = 1'b0;
               state_in           = S_HEAD;
            end else begin
               state_in = S_DSCAN_B;
            end
         end

         S_DSCAN_B: begin
            if (order_rd_ff == tid_idx) begin
               state_in = S_DSHIFT_A;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_DSCAN_A;
            end
         end

         // Move the tail forward one place over the removed task.
         S_DSHIFT_A: begin
            order_raddr = IW'(i_ff + CW'(1));
            if (i_ff + CW'(1) == len_ff) begin
               len_in             = len_ff - CW'(1);
               queued_in[tid_idx] = 1'b0;
               state_in           = S_HEAD;
            end else begin
               state_in = S_DSHIFT_B;
            end
         end

         S_DSHIFT_B: begin
            order_we    = 1'b1;
            order_waddr = i_ff[IW-1:0];
            order_wdata = order_rd_ff;
            i_in        = i_ff + CW'(1);
            state_in    = S_DSHIFT_A;
         end

         // Read the head of the list for the response.
         S_HEAD: begin
            order_raddr = '0;
            state_in    = S_DONE;
         end

         S_DONE: begin
            order_raddr = '0;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= BASE_RESET;
         len_ff       <= '0;
         queued_ff    <= '0;
         info_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         queued_ff    <= queued_in;
         info_vld_ff  <= info_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
      end
   end

   // Working registers and the latched request.
   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      pos_ff     <= pos_in;
      lvl_ff     <= lvl_in;
      resched_ff <= resched_in;
      err_ff     <= err_in;
      if (req_xfer) begin
         mode_ff  <= mode_type'(req_mode);
         tid_ff   <= req_task_id;
         fresh_ff <= req_fresh;
      end
   end

   // Memories with registered reads.
   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
      order_rd_ff <= order_mem[order_raddr];
   end

   always_ff @(posedge clock) begin
      if (info_we) begin
         info_mem[info_waddr] <= info_wdata;
      end
      info_rd_ff     <= info_mem[info_raddr];
      info_vld_rd_ff <= info_vld_ff[info_raddr];
   end

   // Response register, loaded once per transfer.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pick_valid_ff   <= (len_ff != '0);
         rsp_picked_task_ff  <= (len_ff != '0) ? 4'(order_rd_ff) : 4'd0;
         rsp_resched_ff      <= resched_ff;
         rsp_error_ff        <= err_ff;
         rsp_queued_count_ff <= 5'(len_ff);
         rsp_task_level_ff   <= 2'(lvl_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pick_valid   = rsp_pick_valid_ff;
   assign rsp_picked_task  = rsp_picked_task_ff;
   assign rsp_resched      = rsp_resched_ff;
   assign rsp_error        = rsp_error_ff;
   assign rsp_queued_count = rsp_queued_count_ff;
   assign rsp_task_level   = rsp_task_level_ff;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mlfq_pkg::*;

   localparam int TASKS     = NUM_TASKS_DEF;
   localparam int TOP_LEVEL = NUM_LEVELS_DEF - 1;
   localparam int N_ROWS    = 24;
   localparam int N_PHASES  = 5;
   localparam int PHASE_LEN = 90;
   // The tail wait covers the worst request with margin.
   localparam int SETTLE    = 64;

   // One response as it appears on the rsp_ ports.
   typedef struct packed {
      logic       pick_valid;
      logic [3:0] picked_task;
      logic       resched;
      logic       error;
      logic [4:0] queued_count;
      logic [1:0] task_level;
   } status_type;

   // One row of the directed table; want is used only where fixed is set.
   typedef struct packed {
      mode_type   op;
      logic [3:0] tid;
      logic       fresh;
      logic       fixed;
      status_type want;
   } row_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                csr_we    = 1'b0;
   logic [BASE_W-1:0]   csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_mode  = '0;
   logic [3:0]          req_task_id = '0;
   logic                req_fresh = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_pick_valid;
   logic [3:0]          rsp_picked_task;
   logic                rsp_resched;
   logic                rsp_error;
   logic [4:0]          rsp_queued_count;
   logic [1:0]          rsp_task_level;

   // Shadow copy of the scheduler state.
   logic [3:0]          ready_list [TASKS];
   int                  list_len;
   logic [1:0]          lvl_of     [TASKS];
   logic [6:0]          slice_of   [TASKS];
   bit                  on_list    [TASKS];
   logic [BASE_W-1:0]   base_ticks;

   status_type          pending_status [$];
   row_type             directed_rows [N_ROWS];
   int                  mismatches;
   int                  tx_count;
   int                  rx_count;
   int                  rx_hold;

   mlfq_ready_queue_scheduler dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_task_id      (req_task_id),
      .req_fresh        (req_fresh),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pick_valid   (rsp_pick_valid),
      .rsp_picked_task  (rsp_picked_task),
      .rsp_resched      (rsp_resched),
      .rsp_error        (rsp_error),
      .rsp_queued_count (rsp_queued_count),
      .rsp_task_level   (rsp_task_level)
   );

   always #2 clock = ~clock;

   // Slice length that a task at the given level is reloaded with.
   function automatic logic [6:0] reload_ticks(logic [1:0] level);
      return 7'(base_ticks) << level;
   endfunction

   // Apply one operation to the shadow state and return the response it gives.
   function automatic status_type apply_op(mode_type op, logic [3:0] tid, logic fresh);
      status_type s;
      int         pos;
      int         i;
      s = '0;
      case (op)
         MODE_ENQ: begin
            if (on_list[tid] || list_len >= TASKS) begin
               s.error = 1'b1;
            end else begin
               if (fresh) begin
                  lvl_of[tid]   = '0;
                  slice_of[tid] = '0;
               end
               if (slice_of[tid] == 0) slice_of[tid] = reload_ticks(lvl_of[tid]);
               // Insert in front of the first task at a strictly lower priority.
               pos = list_len;
               for (i = 0; i < list_len; i++) begin
                  if (lvl_of[ready_list[i]] > lvl_of[tid]) begin
                     pos = i;
                     break;
                  end
               end
               for (i = list_len; i > pos; i--) ready_list[i] = ready_list[i-1];
               ready_list[pos] = tid;
               list_len++;
               on_list[tid] = 1'b1;
            end
         end
         MODE_DEQ: begin
            if (!on_list[tid]) begin
               s.error = 1'b1;
            end else begin
               pos = list_len;
               for (i = 0; i < list_len; i++) begin
                  if (ready_list[i] == tid) begin
                     pos = i;
                     break;
                  end
               end
               if (pos < list_len) begin
                  for (i = pos; i + 1 < list_len; i++) ready_list[i] = ready_list[i+1];
                  list_len--;
               end
               on_list[tid] = 1'b0;
            end
         end
         MODE_TICK: begin
            // An empty slice counts as exhausted on the first tick.
            if (slice_of[tid] > 0) slice_of[tid]--;
            if (slice_of[tid] == 0) begin
               if (lvl_of[tid] < TOP_LEVEL) lvl_of[tid]++;
               slice_of[tid] = reload_ticks(lvl_of[tid]);
               s.resched = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (op != MODE_PICK) s.task_level = lvl_of[tid];
      s.pick_valid   = (list_len > 0);
      s.picked_task  = (list_len > 0) ? ready_list[0] : 4'd0;
      s.queued_count = 5'(list_len);
      return s;
   endfunction

   // Pick a task that is on the list or off it, at random; any task if none fits.
   function automatic logic [3:0] choose_task(bit queued);
      logic [3:0] cand [$];
      int         i;
      for (i = 0; i < TASKS; i++) begin
         if (on_list[i] == queued) cand.push_back(4'(i));
      end
      if (cand.size() == 0) return 4'($urandom_range(0, TASKS - 1));
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   task automatic note_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Drive one request after a random gap and wait for its transfer.
   task automatic send_item(mode_type op, logic [3:0] tid, logic fresh, logic fixed,
                            status_type want);
      status_type predicted;
      int         gap;
      // Every third stretch of 40 requests goes back to back.
      gap = ((tx_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      predicted = apply_op(op, tid, fresh);
      pending_status.push_back(fixed ? want : predicted);
      req_valid   <= 1'b1;
      req_mode    <= op;
      req_task_id <= tid;
      req_fresh   <= fresh;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tx_count++;
   endtask

   // Hold off the sender until every response has come back.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_base(logic [BASE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      base_ticks = value;
   endtask

   // Response side: random stalls, and a check of every transfer.
   always @(posedge clock) begin : rsp_side
      status_type got;
      status_type want;
      int         hold;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         hold = rx_hold;
         if (rsp_valid && rsp_ready) begin
            rx_count++;
            got = {rsp_pick_valid, rsp_picked_task, rsp_resched, rsp_error,
                   rsp_queued_count, rsp_task_level};
            if (pending_status.size() == 0) begin
               note_mismatch("response with no request pending", 1, 0);
            end else begin
               want = pending_status.pop_front();
               if (got.pick_valid !== want.pick_valid)
                  note_mismatch("pick_valid", got.pick_valid, want.pick_valid);
               if (got.picked_task !== want.picked_task)
                  note_mismatch("picked_task", got.picked_task, want.picked_task);
               if (got.resched !== want.resched)
                  note_mismatch("resched", got.resched, want.resched);
               if (got.error !== want.error)
                  note_mismatch("error", got.error, want.error);
               if (got.queued_count !== want.queued_count)
                  note_mismatch("queued_count", got.queued_count, want.queued_count);
               if (got.task_level !== want.task_level)
                  note_mismatch("task_level", got.task_level, want.task_level);
            end
            hold = ((rx_count / 40) % 3 == 1) ? 0 : $urandom_range(0, 16);
         end else if (hold > 0 && rsp_valid) begin
            hold--;
         end
         rx_hold = hold;
         rsp_ready <= (hold == 0);
      end
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [BASE_W-1:0] phase_base [N_PHASES];
      mode_type          op;
      logic [3:0]        tid;
      int                r;
      int                enq_pct;
      int                ph;
      int                k;

      mismatches = 0;
      tx_count   = 0;
      rx_count   = 0;
      rx_hold    = 0;
      list_len   = 0;
      base_ticks = BASE_RESET;
      for (k = 0; k < TASKS; k++) begin
         ready_list[k] = '0;
         lvl_of[k]     = '0;
         slice_of[k]   = '0;
         on_list[k]    = 1'b0;
      end

      // Zero base slice, both ends of the useful range, the largest code, one more.
      phase_base = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd5};

      // Directed table, run at the reset base slice.
      directed_rows = '{
         // Pick and dequeue on the empty list right after reset.
         '{MODE_PICK, 4'd9,  1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 5'd0, 2'd0}},
         '{MODE_DEQ,  4'd5,  1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b1, 5'd0, 2'd0}},
         // Tick on a task that is not queued and has an empty slice.
         '{MODE_TICK, 4'd15, 1'b0, 1'b0, '0},
         // First enqueue, then the same task again, which is rejected.
         '{MODE_ENQ,  4'd0,  1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 1'b0, 5'd1, 2'd0}},
         '{MODE_ENQ,  4'd0,  1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 1'b1, 5'd1, 2'd0}},
         // A demoted task goes to the tail, a fresh one in front of it.
         '{MODE_ENQ,  4'd15, 1'b0, 1'b0, '0},
         '{MODE_ENQ,  4'd3,  1'b1, 1'b0, '0},
         // Run two slices out, which leaves every queued task at level 1.
         '{MODE_TICK, 4'd3,  1'b0, 1'b0, '0},
         '{MODE_TICK, 4'd3,  1'b0, 1'b0, '0},
         '{MODE_TICK, 4'd0,  1'b1, 1'b0, '0},
         '{MODE_TICK, 4'd0,  1'b0, 1'b0, '0},
         '{MODE_ENQ,  4'd7,  1'b1, 1'b0, '0},
         '{MODE_ENQ,  4'd10, 1'b0, 1'b0, '0},
         '{MODE_PICK, 4'd0,  1'b0, 1'b0, '0},
         // Remove from the middle, the head and the tail, then once too often.
         '{MODE_DEQ,  4'd3,  1'b1, 1'b0, '0},
         '{MODE_DEQ,  4'd7,  1'b0, 1'b0, '0},
         '{MODE_DEQ,  4'd15, 1'b0, 1'b0, '0},
         '{MODE_DEQ,  4'd15, 1'b0, 1'b0, '0},
         // A task demoted while off the list keeps its level and slice.
         '{MODE_TICK, 4'd6,  1'b0, 1'b0, '0},
         '{MODE_ENQ,  4'd6,  1'b0, 1'b0, '0},
         '{MODE_DEQ,  4'd10, 1'b0, 1'b0, '0},
         '{MODE_DEQ,  4'd0,  1'b0, 1'b0, '0},
         '{MODE_DEQ,  4'd6,  1'b0, 1'b0, '0},
         '{MODE_PICK, 4'd15, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 5'd0, 2'd0}}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < N_ROWS; k++) begin
         send_item(directed_rows[k].op, directed_rows[k].tid, directed_rows[k].fresh,
                   directed_rows[k].fixed, directed_rows[k].want);
      end

      // Random phases, one base slice each, written while the block is idle.
      for (ph = 0; ph < N_PHASES; ph++) begin
         drain;
         repeat (4) @(posedge clock);
         write_base(phase_base[ph]);
         for (k = 0; k < PHASE_LEN; k++) begin
            if (k == PHASE_LEN / 2) drain;
            // Swing between filling and emptying the list every 30 requests.
            enq_pct = ((k / 30) % 2 == 0) ? 60 : 20;
            r = $urandom_range(0, 99);
            if (r < enq_pct) begin
               op  = MODE_ENQ;
               tid = choose_task($urandom_range(0, 99) >= 85);
            end else if (r < 80) begin
               op  = MODE_DEQ;
               tid = choose_task($urandom_range(0, 99) < 85);
            end else if (r < 95) begin
               op  = MODE_TICK;
               tid = choose_task($urandom_range(0, 99) < 80);
            end else begin
               op  = MODE_PICK;
               tid = 4'($urandom_range(0, TASKS - 1));
            end
            send_item(op, tid, 1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end

      drain;
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_status.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/mlfq_pkg.sv
sv/mlfq_ready_queue_scheduler.sv
test/testbench.sv
